/* sv/dspf_pkg.sv */
// ----------------------------------------------------------------------------
// dspf_pkg
// Shared types, constants and helpers for the damped spring pair force block.
// ----------------------------------------------------------------------------
package dspf_pkg;

  localparam int FRAC_BITS   = 16;  // fraction bits of positions, k and forces
  localparam int NORM_BITS   = 30;  // fraction bits of the unit normal and ratios
  localparam int DECAY_BITS  = 16;  // fraction bits of velocity_decay
  localparam int ROOT_STEPS  = 33;  // one root bit per stage
  localparam int RATIO_STEPS = 31;  // one quotient bit per stage, mass ratios
  localparam int NORM_STEPS  = 31;  // one quotient bit per stage, normal
  localparam int FMAG_W      = 65 - FRAC_BITS;

  typedef enum logic [1:0] {
    CFG_REST_LENGTH     = 2'd0,
    CFG_SPRING_CONSTANT = 2'd1,
    CFG_VELOCITY_DECAY  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_a_z;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] pos_b_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic [30:0]        inv_mass_a;
    logic [30:0]        inv_mass_b;
  } spring_in_t;

  typedef struct packed {
    logic signed [31:0] force_b_x;
    logic signed [31:0] force_b_y;
    logic signed [31:0] force_b_z;
    logic signed [31:0] dvel_a_x;
    logic signed [31:0] dvel_a_y;
    logic signed [31:0] dvel_a_z;
    logic signed [31:0] dvel_b_x;
    logic signed [31:0] dvel_b_y;
    logic signed [31:0] dvel_b_z;
    logic               damping_applied;
  } spring_out_t;

  typedef struct packed {
    logic [2:0]        d_neg;
    logic [2:0][32:0]  d_mag;
    logic [2:0][31:0]  vel;
    logic [30:0]       ia;
    logic [30:0]       ib;
  } side_t;

  typedef struct packed {
    logic [65:0] sum_sq;
    side_t       side;
  } front_t;

  typedef struct packed {
    logic [32:0]       len;
    logic [2:0]        d_neg;
    logic [2:0][32:0]  d_mag;
    logic [2:0][31:0]  vel;
    logic [30:0]       ra;
    logic [30:0]       rb;
    logic              mass_ok;
  } root_t;

  typedef struct packed {
    logic [32:0]       len;
    logic [2:0]        n_neg;
    logic [2:0][30:0]  n_mag;
    logic [2:0][31:0]  vel;
    logic [30:0]       ra;
    logic [30:0]       rb;
    logic              mass_ok;
  } norm_t;

  // Saturate a sign-magnitude value to signed 32 bits.
  function automatic logic [31:0] sat_sm(input logic [63:0] mag, input logic neg);
    logic [31:0] m32;
    m32 = mag[31:0];
    if (neg) begin
      sat_sm = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~m32 + 32'd1);
    end else begin
      sat_sm = (mag > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m32;
    end
  endfunction

endpackage

/* sv/damped_spring_pair_force_top.sv */
// ----------------------------------------------------------------------------
// damped_spring_pair_force_top
// Hooke spring force and damping velocity changes for one particle pair.
// ----------------------------------------------------------------------------
// One pair enters per clock while no output beat is stalled. The separation
// and its squared length are formed first; the square root is then taken one
// bit per stage (the inverse mass ratios are divided within those stages), the
// unit normal is divided out one quotient bit per stage, and the force and
// damping multiplies, saturation and the output register come last. A stalled
// output beat holds the whole pipeline, bubbles included; with no beat waiting
// at the output every stage advances whatever out_stall says.
module damped_spring_pair_force_top import dspf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  spring_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output spring_out_t out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  logic [30:0] rest_length_r;
  logic [30:0] spring_constant_r;
  logic [16:0] velocity_decay_r;
  logic        en;

  logic   sum_valid, root_valid, norm_valid;
  front_t sum_data;
  root_t  root_data;
  norm_t  norm_data;

  // advance unless the output beat is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_length_r     <= '0;
      spring_constant_r <= '0;
      velocity_decay_r  <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REST_LENGTH:     rest_length_r     <= cfg_wdata;
        CFG_SPRING_CONSTANT: spring_constant_r <= cfg_wdata;
        CFG_VELOCITY_DECAY:  velocity_decay_r  <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  dspf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .sum_valid (sum_valid),
    .sum_data  (sum_data)
  );

  dspf_root u_root (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .sum_valid  (sum_valid),
    .sum_data   (sum_data),
    .root_valid (root_valid),
    .root_data  (root_data)
  );

  dspf_norm u_norm (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .root_valid (root_valid),
    .root_data  (root_data),
    .norm_valid (norm_valid),
    .norm_data  (norm_data)
  );

  dspf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .rest_length     (rest_length_r),
    .spring_constant (spring_constant_r),
    .velocity_decay  (velocity_decay_r),
    .norm_valid      (norm_valid),
    .norm_data       (norm_data),
    .out_valid       (out_valid),
    .out_data        (out_data)
  );

  a_no_damp_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.damping_applied) |->
      (out_data.dvel_a_x == 32'd0 && out_data.dvel_a_y == 32'd0 && out_data.dvel_a_z == 32'd0))
    else $error("velocity change on a without damping");
  a_no_damp_zero_b: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.damping_applied) |->
      (out_data.dvel_b_x == 32'd0 && out_data.dvel_b_y == 32'd0 && out_data.dvel_b_z == 32'd0))
    else $error("velocity change on b without damping");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

/* sv/dspf_front.sv */
// ----------------------------------------------------------------------------
// dspf_front
// Separation vector, its squared components and their sum (three stages).
// ----------------------------------------------------------------------------
module dspf_front import dspf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  spring_in_t in_data,
  output logic       sum_valid,
  output front_t     sum_data
);

  logic signed [31:0] pa [3];
  logic signed [31:0] pb [3];
  logic [32:0]        diff [3];
  side_t              side_nxt;

  logic        v1_r, v2_r, v3_r;
  side_t       side1_r, side2_r, side3_r;
  logic [65:0] sq_r [3];
  logic [65:0] sum_r;

  always_comb begin
    pa[0] = in_data.pos_a_x;
    pa[1] = in_data.pos_a_y;
    pa[2] = in_data.pos_a_z;
    pb[0] = in_data.pos_b_x;
    pb[1] = in_data.pos_b_y;
    pb[2] = in_data.pos_b_z;
    side_nxt.vel[0] = in_data.rel_vel_x;
    side_nxt.vel[1] = in_data.rel_vel_y;
    side_nxt.vel[2] = in_data.rel_vel_z;
    side_nxt.ia     = in_data.inv_mass_a;
    side_nxt.ib     = in_data.inv_mass_b;
    for (int j = 0; j < 3; j++) begin
      diff[j] = {pa[j][31], pa[j]} - {pb[j][31], pb[j]};
      side_nxt.d_neg[j] = diff[j][32];
      side_nxt.d_mag[j] = diff[j][32] ? (~diff[j] + 33'd1) : diff[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_nxt;
      side2_r <= side1_r;
      side3_r <= side2_r;
      for (int j = 0; j < 3; j++) begin
        sq_r[j] <= 66'(side1_r.d_mag[j]) * 66'(side1_r.d_mag[j]);
      end
      sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  assign sum_valid         = v3_r;
  assign sum_data.sum_sq   = sum_r;
  assign sum_data.side     = side3_r;

endmodule

/* sv/dspf_root.sv */
// ----------------------------------------------------------------------------
// dspf_root
// Pipelined integer square root of the squared length, one root bit per stage,
// with the two inverse mass ratio dividers running alongside.
// ----------------------------------------------------------------------------
module dspf_root import dspf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   sum_valid,
  input  front_t sum_data,
  output logic   root_valid,
  output root_t  root_data
);

  logic        v_r        [ROOT_STEPS];
  logic [65:0] op_r       [ROOT_STEPS];
  logic [65:0] res_r      [ROOT_STEPS];
  logic [60:0] ra_rem_r   [ROOT_STEPS];
  logic [60:0] rb_rem_r   [ROOT_STEPS];
  logic [30:0] ra_q_r     [ROOT_STEPS];
  logic [30:0] rb_q_r     [ROOT_STEPS];
  logic [31:0] total_r    [ROOT_STEPS];
  side_t       side_r     [ROOT_STEPS];

  genvar g;
  for (g = 0; g < ROOT_STEPS; g++) begin : g_stage
    logic        v_cur;
    logic [65:0] op_cur, res_cur;
    logic [60:0] ra_rem_cur, rb_rem_cur;
    logic [30:0] ra_q_cur, rb_q_cur;
    logic [31:0] total_cur;
    side_t       side_cur;
    logic [65:0] one, trial, op_nxt, res_nxt;
    logic        root_ge;
    logic [60:0] ra_rem_nxt, rb_rem_nxt;
    logic [30:0] ra_q_nxt, rb_q_nxt;

    if (g == 0) begin : g_first
      assign v_cur      = sum_valid;
      assign op_cur     = sum_data.sum_sq;
      assign res_cur    = '0;
      assign ra_rem_cur = {sum_data.side.ia, {NORM_BITS{1'b0}}};
      assign rb_rem_cur = {sum_data.side.ib, {NORM_BITS{1'b0}}};
      assign ra_q_cur   = '0;
      assign rb_q_cur   = '0;
      assign total_cur  = {1'b0, sum_data.side.ia} + {1'b0, sum_data.side.ib};
      assign side_cur   = sum_data.side;
    end else begin : g_next
      assign v_cur      = v_r[g-1];
      assign op_cur     = op_r[g-1];
      assign res_cur    = res_r[g-1];
      assign ra_rem_cur = ra_rem_r[g-1];
      assign rb_rem_cur = rb_rem_r[g-1];
      assign ra_q_cur   = ra_q_r[g-1];
      assign rb_q_cur   = rb_q_r[g-1];
      assign total_cur  = total_r[g-1];
      assign side_cur   = side_r[g-1];
    end

    // one root bit: subtract the trial square when it fits
    always_comb begin
      one     = 66'd1 << (2 * (ROOT_STEPS - 1 - g));
      trial   = res_cur + one;
      root_ge = (op_cur >= trial);
      op_nxt  = root_ge ? (op_cur - trial) : op_cur;
      res_nxt = root_ge ? ((res_cur >> 1) + one) : (res_cur >> 1);
    end

    if (g < RATIO_STEPS) begin : g_ratio
      localparam int QB = RATIO_STEPS - 1 - g;
      logic [61:0] dsh;
      logic        ga, gb;
      always_comb begin
        dsh        = 62'(total_cur) << QB;
        ga         = ({1'b0, ra_rem_cur} >= dsh);
        gb         = ({1'b0, rb_rem_cur} >= dsh);
        ra_rem_nxt = ga ? (ra_rem_cur - dsh[60:0]) : ra_rem_cur;
        rb_rem_nxt = gb ? (rb_rem_cur - dsh[60:0]) : rb_rem_cur;
        ra_q_nxt   = ra_q_cur | (31'(ga) << QB);
        rb_q_nxt   = rb_q_cur | (31'(gb) << QB);
      end
    end else begin : g_hold
      assign ra_rem_nxt = ra_rem_cur;
      assign rb_rem_nxt = rb_rem_cur;
      assign ra_q_nxt   = ra_q_cur;
      assign rb_q_nxt   = rb_q_cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_r[g]     <= op_nxt;
        res_r[g]    <= res_nxt;
        ra_rem_r[g] <= ra_rem_nxt;
        rb_rem_r[g] <= rb_rem_nxt;
        ra_q_r[g]   <= ra_q_nxt;
        rb_q_r[g]   <= rb_q_nxt;
        total_r[g]  <= total_cur;
        side_r[g]   <= side_cur;
      end
    end
  end

  assign root_valid        = v_r[ROOT_STEPS-1];
  assign root_data.len     = res_r[ROOT_STEPS-1][32:0];
  assign root_data.d_neg   = side_r[ROOT_STEPS-1].d_neg;
  assign root_data.d_mag   = side_r[ROOT_STEPS-1].d_mag;
  assign root_data.vel     = side_r[ROOT_STEPS-1].vel;
  assign root_data.ra      = ra_q_r[ROOT_STEPS-1];
  assign root_data.rb      = rb_q_r[ROOT_STEPS-1];
  assign root_data.mass_ok = (total_r[ROOT_STEPS-1] != 32'd0);

endmodule

/* sv/dspf_norm.sv */
// ----------------------------------------------------------------------------
// dspf_norm
// Unit normal: three pipelined restoring dividers, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dspf_norm import dspf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  root_valid,
  input  root_t root_data,
  output logic  norm_valid,
  output norm_t norm_data
);

  logic             v_r   [NORM_STEPS];
  logic [2:0][62:0] rem_r [NORM_STEPS];
  logic [2:0][30:0] q_r   [NORM_STEPS];
  root_t            rt_r  [NORM_STEPS];

  genvar g;
  for (g = 0; g < NORM_STEPS; g++) begin : g_stage
    localparam int QB = NORM_STEPS - 1 - g;
    logic             v_cur;
    logic [2:0][62:0] rem_cur, rem_nxt;
    logic [2:0][30:0] q_cur, q_nxt;
    root_t            rt_cur;
    logic [63:0]      dsh;
    logic [2:0]       ge;

    if (g == 0) begin : g_first
      assign v_cur  = root_valid;
      assign rt_cur = root_data;
      assign q_cur  = '0;
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          rem_cur[j] = {root_data.d_mag[j], {NORM_BITS{1'b0}}};
        end
      end
    end else begin : g_next
      assign v_cur   = v_r[g-1];
      assign rt_cur  = rt_r[g-1];
      assign q_cur   = q_r[g-1];
      assign rem_cur = rem_r[g-1];
    end

    always_comb begin
      dsh = 64'(rt_cur.len) << QB;
      for (int j = 0; j < 3; j++) begin
        ge[j]      = ({1'b0, rem_cur[j]} >= dsh);
        rem_nxt[j] = ge[j] ? (rem_cur[j] - dsh[62:0]) : rem_cur[j];
        q_nxt[j]   = q_cur[j] | (31'(ge[j]) << QB);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        q_r[g]   <= q_nxt;
        rt_r[g]  <= rt_cur;
      end
    end
  end

  // zero length: force the normal to zero
  always_comb begin
    norm_data.len     = rt_r[NORM_STEPS-1].len;
    norm_data.n_neg   = rt_r[NORM_STEPS-1].d_neg;
    norm_data.vel     = rt_r[NORM_STEPS-1].vel;
    norm_data.ra      = rt_r[NORM_STEPS-1].ra;
    norm_data.rb      = rt_r[NORM_STEPS-1].rb;
    norm_data.mass_ok = rt_r[NORM_STEPS-1].mass_ok;
    for (int j = 0; j < 3; j++) begin
      norm_data.n_mag[j] = (rt_r[NORM_STEPS-1].len == 33'd0) ? 31'd0 : q_r[NORM_STEPS-1][j];
    end
  end

  assign norm_valid = v_r[NORM_STEPS-1];

  a_norm_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    norm_valid |-> norm_data.n_mag[0] <= 31'h4000_0000)
    else $error("normal x above one");
  a_norm_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    norm_valid |-> norm_data.n_mag[1] <= 31'h4000_0000)
    else $error("normal y above one");
  a_norm_z_bound: assert property (@(posedge clk) disable iff (!rst_n)
    norm_valid |-> norm_data.n_mag[2] <= 31'h4000_0000)
    else $error("normal z above one");

endmodule

/* sv/dspf_back.sv */
// ----------------------------------------------------------------------------
// dspf_back
// Spring force and damping impulse multiplies, saturation and output register.
// ----------------------------------------------------------------------------
module dspf_back import dspf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [30:0] rest_length,
  input  logic [30:0] spring_constant,
  input  logic [16:0] velocity_decay,
  input  logic        norm_valid,
  input  norm_t       norm_data,
  output logic        out_valid,
  output spring_out_t out_data
);

  typedef struct packed {
    logic [2:0]       n_neg;
    logic [2:0][30:0] n_mag;
    logic [30:0]      ra;
    logic [30:0]      rb;
    logic             mass_ok;
  } carry_t;

  logic   v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;
  carry_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  // stage 1: stretch, velocity times normal
  logic [34:0]        st;
  logic signed [31:0] ns [3];
  logic               st_neg_r;
  logic [33:0]        st_mag_r;
  logic signed [63:0] p_r [3];

  // stage 2
  logic [64:0]        e_prod [3];
  logic [33:0]        e_mag_r [3];
  logic [2:0]         e_neg_r;
  logic signed [63:0] vsum_r;

  // stage 3
  logic [64:0]        f_prod [3];
  logic [FMAG_W-1:0]  f_mag_r [3];
  logic [2:0]         f_neg_r;
  logic [63:0]        vabs;
  logic [33:0]        vrel_mag_r;
  logic               vrel_neg_r;

  // stage 4
  logic [17:0]        fac;
  logic [16:0]        fac_mag;
  logic [50:0]        dv_prod;
  logic [31:0]        force4_r [3];
  logic [33:0]        dv_mag_r;
  logic               dv_neg_r;

  // stage 5
  logic [64:0]        sa_prod, sb_prod;
  logic [31:0]        force5_r [3];
  logic [33:0]        sa_mag_r, sb_mag_r;
  logic               dv5_neg_r;

  // stage 6
  logic [64:0]        da_prod [3];
  logic [64:0]        db_prod [3];
  logic [31:0]        force6_r [3];
  logic [33:0]        da_mag_r [3];
  logic [33:0]        db_mag_r [3];
  logic [2:0]         da_neg_r, db_neg_r;

  spring_out_t        out_r;

  always_comb begin
    st = {2'b00, norm_data.len} - {4'b0000, rest_length};
    for (int j = 0; j < 3; j++) begin
      ns[j] = norm_data.n_neg[j] ? -$signed({1'b0, norm_data.n_mag[j]})
                                 : $signed({1'b0, norm_data.n_mag[j]});
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e_prod[j] = 65'(st_mag_r) * 65'(c1_r.n_mag[j]);
      f_prod[j] = 65'(spring_constant) * 65'(e_mag_r[j]);
      sa_prod   = 65'(dv_mag_r) * 65'(c4_r.ra);
      sb_prod   = 65'(dv_mag_r) * 65'(c4_r.rb);
      da_prod[j] = 65'(sa_mag_r) * 65'(c5_r.n_mag[j]);
      db_prod[j] = 65'(sb_mag_r) * 65'(c5_r.n_mag[j]);
    end
    vabs    = vsum_r[63] ? 64'(-vsum_r) : 64'(vsum_r);
    fac     = {1'b0, velocity_decay} - 18'd65536;
    fac_mag = fac[17] ? 17'(-fac) : fac[16:0];
    dv_prod = 51'(vrel_mag_r) * 51'(fac_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= norm_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      c1_r.n_neg   <= norm_data.n_neg;
      c1_r.n_mag   <= norm_data.n_mag;
      c1_r.ra      <= norm_data.ra;
      c1_r.rb      <= norm_data.rb;
      c1_r.mass_ok <= norm_data.mass_ok;
      st_neg_r     <= st[34];
      st_mag_r     <= st[34] ? 34'(-st) : st[33:0];
      for (int j = 0; j < 3; j++) begin
        p_r[j] <= 64'($signed(norm_data.vel[j])) * 64'(ns[j]);
      end
      // stage 2
      c2_r   <= c1_r;
      vsum_r <= p_r[0] + p_r[1] + p_r[2];
      for (int j = 0; j < 3; j++) begin
        e_mag_r[j] <= e_prod[j][63:NORM_BITS];
        e_neg_r[j] <= st_neg_r ^ c1_r.n_neg[j];
      end
      // stage 3
      c3_r       <= c2_r;
      vrel_neg_r <= vsum_r[63];
      vrel_mag_r <= vabs[63:NORM_BITS];
      for (int j = 0; j < 3; j++) begin
        f_mag_r[j] <= f_prod[j][64:FRAC_BITS];
        f_neg_r[j] <= e_neg_r[j];
      end
      // stage 4
      c4_r     <= c3_r;
      dv_mag_r <= dv_prod[49:DECAY_BITS];
      dv_neg_r <= vrel_neg_r ^ fac[17];
      for (int j = 0; j < 3; j++) begin
        force4_r[j] <= sat_sm(64'(f_mag_r[j]), f_neg_r[j]);
      end
      // stage 5
      c5_r      <= c4_r;
      force5_r  <= force4_r;
      sa_mag_r  <= sa_prod[63:NORM_BITS];
      sb_mag_r  <= sb_prod[63:NORM_BITS];
      dv5_neg_r <= dv_neg_r;
      // stage 6
      c6_r     <= c5_r;
      force6_r <= force5_r;
      for (int j = 0; j < 3; j++) begin
        da_mag_r[j] <= da_prod[j][63:NORM_BITS];
        db_mag_r[j] <= db_prod[j][63:NORM_BITS];
        da_neg_r[j] <= dv5_neg_r ^ c5_r.n_neg[j];
        db_neg_r[j] <= ~(dv5_neg_r ^ c5_r.n_neg[j]);
      end
      // output beat; drop the velocity changes when the masses are all infinite
      out_r.force_b_x       <= force6_r[0];
      out_r.force_b_y       <= force6_r[1];
      out_r.force_b_z       <= force6_r[2];
      out_r.dvel_a_x        <= c6_r.mass_ok ? sat_sm(64'(da_mag_r[0]), da_neg_r[0]) : 32'd0;
      out_r.dvel_a_y        <= c6_r.mass_ok ? sat_sm(64'(da_mag_r[1]), da_neg_r[1]) : 32'd0;
      out_r.dvel_a_z        <= c6_r.mass_ok ? sat_sm(64'(da_mag_r[2]), da_neg_r[2]) : 32'd0;
      out_r.dvel_b_x        <= c6_r.mass_ok ? sat_sm(64'(db_mag_r[0]), db_neg_r[0]) : 32'd0;
      out_r.dvel_b_y        <= c6_r.mass_ok ? sat_sm(64'(db_mag_r[1]), db_neg_r[1]) : 32'd0;
      out_r.dvel_b_z        <= c6_r.mass_ok ? sat_sm(64'(db_mag_r[2]), db_neg_r[2]) : 32'd0;
      out_r.damping_applied <= c6_r.mass_ok;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
